### design/sort_pkg.sv
// Package with the shared types and constants of the switch output reservation table.
`default_nettype none
package sort_pkg;

  localparam int NUM_OUTPUTS_DEF = 5;
  localparam int MAX_RES_DEF = 4;
  localparam int MAX_OUT = 5;
  localparam int RW = $clog2(MAX_OUT + 1);
  localparam int BW = $clog2(MAX_OUT);
  localparam int EW = 9;

  typedef enum logic [2:0] {
    OP_CHECK   = 3'd0,
    OP_RESERVE = 3'd1,
    OP_RELEASE = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_QIN     = 3'd4,
    OP_QOUT    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_AVAIL    = 3'd0,
    ST_ENCODE   = 3'd1,
    ST_BUSY     = 3'd2,
    ST_SAME     = 3'd3,
    ST_OTHER    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_CODING  = 2'd0,
    CFG_MAXMULT = 2'd1,
    CFG_LOCAL   = 2'd2
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_STAIL, S_DECIDE, S_SHIFT, S_RFIN, S_QIN, S_QOUT, S_QTAIL, S_EMIT
  } state_t;

endpackage
`default_nettype wire

### design/sort_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module sort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/switch_output_reservation_table_top.sv
// Top level of the switch output reservation table: sequencer, per-output state and entry RAM.
// One item is taken when start is high and busy is low; busy stays high until the cycle that
// carries the final result. Results come one per cycle on done and cannot be held off; last
// marks the final one. The entries live in one RAM read one word per cycle, so check,
// reserve and release with a valid output port scan all NUM_OUTPUTS*MAX_RES words,
// release then moves the tail of the list one word per cycle, query by input reads
// one word per output, and query by output one per reported entry. Advance and unknown
// operations go straight from idle to the result.
`default_nettype none
module switch_output_reservation_table_top #(
  parameter int NUM_OUTPUTS = sort_pkg::NUM_OUTPUTS_DEF,
  parameter int MAX_RES = sort_pkg::MAX_RES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] operation,
  input  wire logic [2:0] out_port,
  input  wire logic [2:0] in_port,
  input  wire logic [1:0] chan,
  input  wire logic [3:0] mult,
  input  wire logic       head_coded,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            done,
  output logic [2:0]      status,
  output logic            found,
  output logic [2:0]      res_port,
  output logic [1:0]      res_chan,
  output logic [2:0]      res_count,
  output logic            coding_active,
  output logic            last
);
  import sort_pkg::*;

  localparam int OW = $clog2(NUM_OUTPUTS);
  localparam int IW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int CW = $clog2(MAX_RES + 1);
  localparam int DEPTH = NUM_OUTPUTS * MAX_RES;
  localparam int AW = $clog2(DEPTH);

  logic          coding_mode;
  logic [7:0]    max_mult;
  logic [2:0]    local_port;

  logic [CW-1:0] cnt  [NUM_OUTPUTS];
  logic [IW-1:0] rr   [NUM_OUTPUTS];
  logic [7:0]    msum [NUM_OUTPUTS];
  logic          mrg  [NUM_OUTPUTS];
  logic          hcs  [NUM_OUTPUTS];

  state_t        state, state_next;
  op_t           op_r;
  logic [2:0]    po_r, inp_r;
  logic [1:0]    ch_r;
  logic [3:0]    m_r;
  logic          hc_r;
  logic          po_ok;
  logic [OW-1:0] pidx;

  logic [OW-1:0] so;
  logic [IW-1:0] si;
  logic          pv;
  logic [OW-1:0] p_o;
  logic [IW-1:0] p_i;
  logic          hit_f;
  status_t       hit_st;
  logic          eqf;
  logic [IW-1:0] eqpos;
  logic [3:0]    eqmult;
  logic [IW-1:0] shj, sdst;
  logic          sv;
  logic [OW-1:0] qo;
  logic [IW-1:0] qi;
  logic [CW-1:0] qleft;
  status_t       st_r;
  logic [2:0]    buf_port [MAX_OUT];
  logic [1:0]    buf_chan [MAX_OUT];
  logic [RW-1:0] nres;
  logic [BW-1:0] ei;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [2:0]    e_in;
  logic [1:0]    e_ch;
  logic [3:0]    e_m;
  status_t       st;
  logic          ein_ok;
  logic [OW-1:0] in_idx;
  logic          e_valid;
  logic          shift_go;
  logic          emit_last;

  assign e_in = rdata[8:6];
  assign e_ch = rdata[5:4];
  assign e_m  = rdata[3:0];
  assign pidx = po_r[OW-1:0];
  assign in_idx = out_port[OW-1:0];
  assign ein_ok = ({1'b0, out_port} < 4'(NUM_OUTPUTS));
  assign e_valid = (CW'(p_i) < cnt[p_o]);
  assign shift_go = ((CW + 1)'(shj) + (CW + 1)'(1)) < (CW + 1)'(cnt[pidx]);
  assign emit_last = (nres == '0) || ({1'b0, ei} == (RW + 1)'(nres) - (RW + 1)'(1));
  assign busy = (state != S_IDLE);

  sort_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode <= 1'b0;
      max_mult <= 8'd8;
      local_port <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODING:  coding_mode <= cfg_data[0];
        CFG_MAXMULT: max_mult <= cfg_data;
        CFG_LOCAL:   local_port <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st = ST_AVAIL;
    if (!coding_mode && hit_f) begin
      st = hit_st;
    end else if (coding_mode && ({1'b0, msum[pidx]} + 9'(m_r) > {1'b0, max_mult})) begin
      st = ST_BUSY;
    end else if (eqf) begin
      st = ST_SAME;
    end else if (int'(cnt[pidx]) >= MAX_RES) begin
      st = ST_BUSY;
    end else if (cnt[pidx] != '0) begin
      st = (po_r == local_port || hcs[pidx]) ? ST_BUSY : ST_ENCODE;
    end
  end

  always_comb begin
    state_next = state;
    raddr = '0;
    we = 1'b0;
    waddr = AW'(sdst) + AW'(pidx) * AW'(MAX_RES);
    wdata = rdata;
    if (sv) begin
      we = 1'b1;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_CHECK, OP_RESERVE, OP_RELEASE: state_next = ein_ok ? S_SCAN : S_EMIT;
            OP_QIN:  state_next = S_QIN;
            OP_QOUT: state_next = (ein_ok && cnt[in_idx] != '0) ? S_QOUT : S_EMIT;
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        raddr = AW'(si) + AW'(so) * AW'(MAX_RES);
        if (so == OW'(NUM_OUTPUTS - 1) && si == IW'(MAX_RES - 1)) begin
          state_next = S_STAIL;
        end
      end
      S_STAIL: state_next = S_DECIDE;
      S_DECIDE: begin
        if (op_r == OP_RELEASE) begin
          state_next = eqf ? S_SHIFT : S_EMIT;
        end else begin
          state_next = S_EMIT;
          if (op_r == OP_RESERVE && (st == ST_AVAIL || st == ST_ENCODE)) begin
            we = 1'b1;
            waddr = AW'(cnt[pidx]) + AW'(pidx) * AW'(MAX_RES);
            wdata = {inp_r, ch_r, m_r};
          end
        end
      end
      S_SHIFT: begin
        raddr = AW'(IW'(shj + IW'(1))) + AW'(pidx) * AW'(MAX_RES);
        if (!shift_go) begin
          state_next = S_RFIN;
        end
      end
      S_RFIN: state_next = S_EMIT;
      S_QIN: begin
        raddr = AW'(rr[qo]) + AW'(qo) * AW'(MAX_RES);
        if (qo == OW'(NUM_OUTPUTS - 1)) begin
          state_next = S_QTAIL;
        end
      end
      S_QOUT: begin
        raddr = AW'(qi) + AW'(pidx) * AW'(MAX_RES);
        if (qleft == CW'(1)) begin
          state_next = S_QTAIL;
        end
      end
      S_QTAIL: state_next = S_EMIT;
      S_EMIT: begin
        if (emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < NUM_OUTPUTS; o++) begin
        cnt[o] <= '0;
        rr[o] <= '0;
        msum[o] <= '0;
        mrg[o] <= 1'b0;
        hcs[o] <= 1'b0;
      end
      pv <= 1'b0;
      sv <= 1'b0;
      done <= 1'b0;
      nres <= '0;
      hit_f <= 1'b0;
      eqf <= 1'b0;
    end else begin
      pv <= 1'b0;
      sv <= 1'b0;
      done <= 1'b0;
      // collect scan results
      if (pv && (state == S_SCAN || state == S_STAIL) && e_valid) begin
        if (p_o == pidx) begin
          if (!hit_f && e_in != inp_r && e_ch == ch_r) begin
            hit_f <= 1'b1;
            hit_st <= ST_BUSY;
          end
          if (!eqf && e_in == inp_r && e_ch == ch_r) begin
            eqf <= 1'b1;
            eqpos <= p_i;
            eqmult <= e_m;
          end
        end else if (!hit_f && e_in == inp_r && e_ch == ch_r) begin
          hit_f <= 1'b1;
          hit_st <= ST_OTHER;
        end
      end
      // collect query hits
      if (pv && (state == S_QIN || state == S_QOUT || state == S_QTAIL)) begin
        if ((op_r == OP_QOUT || e_in == inp_r) && int'(nres) < MAX_OUT) begin
          buf_port[nres[BW-1:0]] <= (op_r == OP_QOUT) ? e_in : 3'(p_o);
          buf_chan[nres[BW-1:0]] <= e_ch;
          nres <= nres + RW'(1);
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r <= op_t'(operation);
            po_r <= out_port;
            inp_r <= in_port;
            ch_r <= chan;
            m_r <= mult;
            hc_r <= head_coded;
            po_ok <= ein_ok;
            hit_f <= 1'b0;
            eqf <= 1'b0;
            nres <= '0;
            ei <= '0;
            so <= '0;
            si <= '0;
            qo <= '0;
            st_r <= ST_AVAIL;
            if (!ein_ok) begin
              if (operation == OP_CHECK || operation == OP_RESERVE) begin
                st_r <= ST_BUSY;
              end else if (operation == OP_RELEASE) begin
                st_r <= ST_NOTFOUND;
              end
            end
            if (operation == OP_ADVANCE) begin
              for (int o = 0; o < NUM_OUTPUTS; o++) begin
                if (cnt[o] != '0) begin
                  rr[o] <= (CW'(rr[o]) + CW'(1) == cnt[o]) ? '0 : IW'(rr[o] + IW'(1));
                end
              end
            end
            if (ein_ok && cnt[in_idx] > CW'(1) && mrg[in_idx]) begin
              qi <= '0;
              qleft <= (int'(cnt[in_idx]) > MAX_OUT) ? CW'(MAX_OUT) : cnt[in_idx];
            end else begin
              qi <= (cnt[in_idx] == CW'(1)) ? '0 : rr[in_idx];
              qleft <= CW'(1);
            end
          end
        end
        S_SCAN: begin
          pv <= 1'b1;
          p_o <= so;
          p_i <= si;
          if (si == IW'(MAX_RES - 1)) begin
            si <= '0;
            so <= OW'(so + OW'(1));
          end else begin
            si <= IW'(si + IW'(1));
          end
        end
        S_DECIDE: begin
          st_r <= st;
          if (op_r == OP_RELEASE) begin
            if (eqf) begin
              msum[pidx] <= msum[pidx] - 8'(eqmult);
              shj <= eqpos;
              st_r <= ST_AVAIL;
            end else begin
              st_r <= ST_NOTFOUND;
            end
          end else if (op_r == OP_RESERVE && (st == ST_AVAIL || st == ST_ENCODE)) begin
            if (coding_mode) begin
              if (cnt[pidx] == '0) begin
                hcs[pidx] <= hc_r;
              end else if (!mrg[pidx]) begin
                mrg[pidx] <= 1'b1;
                hcs[pidx] <= 1'b1;
              end
            end
            cnt[pidx] <= cnt[pidx] + CW'(1);
            msum[pidx] <= msum[pidx] + 8'(m_r);
          end
        end
        S_SHIFT: begin
          if (shift_go) begin
            sv <= 1'b1;
            sdst <= shj;
            shj <= IW'(shj + IW'(1));
          end
        end
        S_RFIN: begin
          cnt[pidx] <= cnt[pidx] - CW'(1);
          if (eqpos < rr[pidx]) begin
            rr[pidx] <= rr[pidx] - IW'(1);
          end else if (CW'(rr[pidx]) >= cnt[pidx] - CW'(1)) begin
            rr[pidx] <= '0;
          end
          if (cnt[pidx] == CW'(1)) begin
            mrg[pidx] <= 1'b0;
            hcs[pidx] <= 1'b0;
          end
        end
        S_QIN: begin
          pv <= (cnt[qo] != '0);
          p_o <= qo;
          qo <= OW'(qo + OW'(1));
        end
        S_QOUT: begin
          pv <= 1'b1;
          qi <= IW'(qi + IW'(1));
          qleft <= qleft - CW'(1);
        end
        S_EMIT: begin
          done <= 1'b1;
          status <= (nres == '0) ? st_r : ST_AVAIL;
          found <= (nres != '0);
          res_port <= (nres != '0) ? buf_port[ei] : 3'd0;
          res_chan <= (nres != '0) ? buf_chan[ei] : 2'd0;
          res_count <= po_ok ? 3'(cnt[pidx]) : 3'd0;
          coding_active <= po_ok ? mrg[pidx] : 1'b0;
          last <= emit_last;
          ei <= BW'(ei + BW'(1));
        end
        default: ;
      endcase
    end
  end

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy) else $error("busy after final result");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy) else $error("idle before final result");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done) else $error("result right after accept");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == ST_AVAIL) else $error("entry result with status");

endmodule
`default_nettype wire
